/* hw/rtl/b64d_pkg.sv */
// shared types, constants and character classifier for the base64 stream decoder
package b64d_pkg;

   localparam int CHAR_W = 8;
   localparam int SEXTET_W = 6;
   localparam int MAX_RESULTS = 3;
   localparam logic [CHAR_W-1:0] PAD_CHAR = 8'h3d;

   typedef enum logic [1:0] {
      STATUS_DATA       = 2'd0,
      STATUS_BAD_CHAR   = 2'd1,
      STATUS_BAD_LENGTH = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      CLS_LEGAL = 2'd0,
      CLS_PAD   = 2'd1,
      CLS_BAD   = 2'd2
   } char_class_type;

   typedef struct packed {
      char_class_type        cls;
      logic [SEXTET_W-1:0]   value;
   } char_code_type;

   typedef struct packed {
      logic                message_end;
      logic                run_last;
      status_type          status;
      logic                is_filler;
      logic [CHAR_W-1:0]   data_byte;
   } rsp_type;

   typedef struct packed {
      logic [1:0]                  count;
      rsp_type [MAX_RESULTS-1:0]   res;
   } batch_type;

   function automatic char_code_type classify(input logic [CHAR_W-1:0] c);
      char_code_type code;
      code.cls = CLS_BAD;
      code.value = '0;
      if (c inside {[8'h41:8'h5a]}) begin
         code.cls = CLS_LEGAL;
         code.value = SEXTET_W'(c - 8'h41);
      end else if (c inside {[8'h61:8'h7a]}) begin
         code.cls = CLS_LEGAL;
         code.value = SEXTET_W'(c - 8'd71);
      end else if (c inside {[8'h30:8'h39]}) begin
         code.cls = CLS_LEGAL;
         code.value = SEXTET_W'(c + 8'd4);
      end else if (c == 8'h2b) begin
         code.cls = CLS_LEGAL;
         code.value = 6'd62;
      end else if (c == 8'h2f) begin
         code.cls = CLS_LEGAL;
         code.value = 6'd63;
      end else if (c == PAD_CHAR) begin
         code.cls = CLS_PAD;
      end
      return code;
   endfunction

endpackage

/* hw/rtl/base64_stream_decoder_unit.sv */
// top level of the streaming base64 decoder
// Takes one base64 character per beat (standard alphabet, '=' padding) with
// tlast on the final character of a message, and gives three decoded bytes,
// one per cycle while the sink is ready, after every fourth character; bytes
// from padding come out as zero with the filler flag. An illegal character,
// misplaced padding or a message length that is not a multiple of four gives
// one error beat, queued behind earlier results, and the rest of that message
// is dropped. A character is taken in every cycle as long as the result queue
// has room for three entries; the output side gives one byte per cycle, so a
// steady stream runs at one character per cycle when the sink takes a beat
// every cycle. QUEUE_DEPTH (at least four) sets how much output stalling the
// queue absorbs before the input side is held.
module base64_stream_decoder_unit
   import b64d_pkg::*;
#(
   parameter int QUEUE_DEPTH = 8
)
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // char_byte
   input  logic         req_tlast,   // msg_last
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [7:0]   rsp_tdata,   // data_byte
   output logic [3:0]   rsp_tuser,   // run_last, status[1:0], is_filler
   output logic         rsp_tlast    // message_end
);

   batch_type batch;
   rsp_type   head;
   logic      room;
   logic      accept;

   assign req_tready = room;
   assign accept = req_tvalid && room;

   b64d_core u_core (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .char_byte (req_tdata),
      .msg_last  (req_tlast),
      .batch     (batch)
   );

   b64d_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (batch),
      .pop        (rsp_tvalid && rsp_tready),
      .head       (head),
      .head_valid (rsp_tvalid),
      .room       (room)
   );

   assign rsp_tdata = head.data_byte;
   assign rsp_tuser = {head.run_last, head.status, head.is_filler};
   assign rsp_tlast = head.message_end;

endmodule

/* hw/rtl/b64d_core.sv */
// group state and per-character decode, up to three results per accepted beat
module b64d_core
   import b64d_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic [CHAR_W-1:0]   char_byte,
   input  logic                msg_last,
   output batch_type           batch
);

   logic [SEXTET_W-1:0] sextet_ff [3];
   logic [SEXTET_W-1:0] sextet_in [3];
   logic                pad2_ff;
   logic                pad2_in;
   logic [1:0]          pos_ff;
   logic [1:0]          pos_in;
   logic                discard_ff;
   logic                discard_in;

   char_code_type       code;
   logic                pad3;
   rsp_type             err_rsp;
   logic                fail;
   status_type          fail_status;

   always_comb begin
      code = classify(char_byte);
      pad3 = (code.cls == CLS_PAD);
      sextet_in = sextet_ff;
      pad2_in = pad2_ff;
      pos_in = pos_ff;
      discard_in = discard_ff;
      fail = 1'b0;
      fail_status = STATUS_DATA;
      err_rsp = '0;
      batch = '0;

      if (accept) begin
         if (discard_ff) begin
            if (msg_last) begin
               discard_in = 1'b0;
               pos_in = 2'd0;
               pad2_in = 1'b0;
            end
         end else if (msg_last && pos_ff != 2'd3) begin
            fail = 1'b1;
            fail_status = STATUS_BAD_LENGTH;
         end else if (code.cls == CLS_BAD) begin
            fail = 1'b1;
            fail_status = STATUS_BAD_CHAR;
         end else if (pos_ff < 2'd2 && pad3) begin
            fail = 1'b1;
            fail_status = STATUS_BAD_CHAR;
         end else if (pos_ff != 2'd3) begin
            sextet_in[pos_ff] = code.value;
            if (pos_ff == 2'd2) begin
               pad2_in = pad3;
            end
            pos_in = pos_ff + 2'd1;
         end else if ((!msg_last && (pad2_ff || pad3)) || (pad2_ff && !pad3)) begin
            fail = 1'b1;
            fail_status = STATUS_BAD_CHAR;
         end else begin
            // full group: three bytes, padded positions come out as zero filler
            batch.count = 2'd3;
            batch.res[0].data_byte = {sextet_ff[0], sextet_ff[1][5:4]};
            batch.res[1].data_byte = pad2_ff ? '0 : {sextet_ff[1][3:0], sextet_ff[2][5:2]};
            batch.res[1].is_filler = pad2_ff;
            batch.res[2].data_byte = pad3 ? '0 : {sextet_ff[2][1:0], code.value};
            batch.res[2].is_filler = pad3;
            batch.res[2].run_last = 1'b1;
            batch.res[2].message_end = msg_last;
            pos_in = 2'd0;
            pad2_in = 1'b0;
         end

         if (fail) begin
            err_rsp.status = fail_status;
            err_rsp.run_last = 1'b1;
            err_rsp.message_end = 1'b1;
            batch.count = 2'd1;
            batch.res[0] = err_rsp;
            pos_in = 2'd0;
            pad2_in = 1'b0;
            discard_in = !msg_last;
         end
      end
   end

   always_ff @(posedge clock) begin
      sextet_ff <= sextet_in;
      if (reset) begin
         pad2_ff <= 1'b0;
         pos_ff <= 2'd0;
         discard_ff <= 1'b0;
      end else begin
         pad2_ff <= pad2_in;
         pos_ff <= pos_in;
         discard_ff <= discard_in;
      end
   end

endmodule

/* hw/rtl/b64d_queue.sv */
// result queue taking up to three entries per cycle and giving one per cycle while popped
module b64d_queue
   import b64d_pkg::*;
#(
   parameter int DEPTH = 8
)
(
   input  logic      clock,
   input  logic      reset,
   input  batch_type push,
   input  logic      pop,
   output rsp_type   head,
   output logic      head_valid,
   output logic      room
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   rsp_type           mem [DEPTH];
   logic [PTR_W-1:0]  rd_ptr_ff;
   logic [PTR_W-1:0]  rd_ptr_in;
   logic [PTR_W-1:0]  wr_ptr_ff;
   logic [PTR_W-1:0]  wr_ptr_in;
   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  count_in;

   function automatic logic [PTR_W-1:0] ptr_add(input logic [PTR_W-1:0] ptr,
                                                input logic [1:0] k);
      logic [PTR_W:0] sum;
      sum = {1'b0, ptr} + (PTR_W + 1)'(k);
      if (sum >= (PTR_W + 1)'(DEPTH)) begin
         sum = sum - (PTR_W + 1)'(DEPTH);
      end
      return sum[PTR_W-1:0];
   endfunction

   always_comb begin
      rd_ptr_in = pop ? ptr_add(rd_ptr_ff, 2'd1) : rd_ptr_ff;
      wr_ptr_in = ptr_add(wr_ptr_ff, push.count);
      count_in = count_ff + CNT_W'(push.count) - CNT_W'(pop);
   end

   assign head = mem[rd_ptr_ff];
   assign head_valid = (count_ff != '0);
   assign room = (count_ff <= CNT_W'(DEPTH - MAX_RESULTS));

   always_ff @(posedge clock) begin
      for (int k = 0; k < MAX_RESULTS; k++) begin
         if (2'(k) < push.count) begin
            mem[ptr_add(wr_ptr_ff, 2'(k))] <= push.res[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff <= count_in;
      end
   end

endmodule
